// ----- design/fbpa_pkg.sv -----
// Shared types and constants for the fixed block pool allocator.
// No dependencies; every other design file refers to it by scoped name.
package fbpa_pkg;

   localparam int OFFSET_W = 16;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_MISALIGN = 2'd3
   } status_type;

   typedef enum logic {
      ACTION_ALLOC = 1'b0,
      ACTION_FREE  = 1'b1
   } action_type;

   // controller -> datapath
   typedef struct packed {
      logic init_step;
      logic start_alloc;
      logic start_free;
      logic finish_alloc;
      logic finish_free;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic init_last;
      logic out_free;
   } stat_type;

endpackage

// ----- design/fbpa_ifs.sv -----
// Valid/ready channel interfaces for the allocator's request and response beats.
// Depends on fbpa_pkg for the payload widths.
interface fbpa_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [fbpa_pkg::OFFSET_W-1:0] free_offset;

   modport source (output valid, action, free_offset, input ready);
   modport sink (input valid, action, free_offset, output ready);
   modport monitor (input valid, ready, action, free_offset);
endinterface

interface fbpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fbpa_pkg::STATUS_W-1:0] status;
   logic [fbpa_pkg::OFFSET_W-1:0] alloc_offset;

   modport source (output valid, status, alloc_offset, input ready);
   modport sink (input valid, status, alloc_offset, output ready);
   modport monitor (input valid, ready, status, alloc_offset);
endinterface

// ----- design/fixed_block_pool_allocator_top.sv -----
// Top level of the fixed block pool allocator: controller plus datapath.
// Depends on fbpa_pkg, fbpa_ifs (channel interfaces), fbpa_ctrl and fbpa_dp.
//
// Hands out and takes back equal-size blocks of a pool of BLOCK_COUNT blocks of
// BLOCK_BYTES bytes, keeping a last-in-first-out free list in a next-pointer
// table memory. A request beat either allocates (answer: byte offset of the
// block, or status empty) or frees a byte offset (rejected as out of range, then
// as misaligned; otherwise pushed onto the list). Double frees are not caught.
// Only blocks whose offset fits in 16 bits are used. After reset the block runs
// a clearing pass over all BLOCK_COUNT table entries that chains the blocks in
// ascending order; req ready stays low until it is done. Each accepted request
// then finishes once the response register can take its beat: an allocate
// first registers the read of the head's next pointer; a free registers the
// block index from the reciprocal multiply of the offset, then does the check
// and table write. One request is in work at a time; the response register
// lets a new request in while the previous response beat waits.
module fixed_block_pool_allocator_top #(
   parameter int BLOCK_COUNT = 64,
   parameter int BLOCK_BYTES = 64
) (
   input logic        clock,
   input logic        reset,
   fbpa_req_if.sink   req_chan,
   fbpa_rsp_if.source rsp_chan
);

   fbpa_pkg::cmd_type  cmd;
   fbpa_pkg::stat_type stat;

   fbpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fbpa_dp #(
      .BLOCK_COUNT (BLOCK_COUNT),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_free_offset  (req_chan.free_offset),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_alloc_offset (rsp_chan.alloc_offset)
   );

endmodule

// ----- design/fbpa_ctrl.sv -----
// Sequencing state machine for the allocator: clearing pass, accept, finish.
// Depends on fbpa_pkg; drives fbpa_dp through cmd_type and reads stat_type.
module fbpa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_action,
   output logic                req_ready,
   input  fbpa_pkg::stat_type  stat,
   output fbpa_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_ALLOC,
      S_FREE
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      accept;

   assign req_ready = ready_ff;
   assign accept    = req_valid & ready_ff;

   always_comb begin
      cmd.init_step    = (state_ff == S_INIT);
      cmd.start_alloc  = accept & (req_action == fbpa_pkg::ACTION_ALLOC);
      cmd.start_free   = accept & (req_action == fbpa_pkg::ACTION_FREE);
      cmd.finish_alloc = (state_ff == S_ALLOC) & stat.out_free;
      cmd.finish_free  = (state_ff == S_FREE) & stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_INIT: begin
               if (stat.init_last) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  state_ff <= (req_action == fbpa_pkg::ACTION_FREE) ? S_FREE : S_ALLOC;
                  ready_ff <= 1'b0;
               end
            end
            S_ALLOC, S_FREE: begin
               // finish only when the response register can take the beat
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_INIT;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

// ----- design/fbpa_dp.sv -----
// Allocator datapath: head register, next-pointer table memory, offset math,
// response register. Depends on fbpa_pkg; commanded by fbpa_ctrl.
module fbpa_dp #(
   parameter int BLOCK_COUNT = 64,
   parameter int BLOCK_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fbpa_pkg::cmd_type             cmd,
   output fbpa_pkg::stat_type            stat,
   input  logic [fbpa_pkg::OFFSET_W-1:0] req_free_offset,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fbpa_pkg::STATUS_W-1:0] rsp_status,
   output logic [fbpa_pkg::OFFSET_W-1:0] rsp_alloc_offset
);

   localparam int OFF_W    = fbpa_pkg::OFFSET_W;
   localparam int IDX_W    = $clog2(BLOCK_COUNT + 1);
   localparam int ADDR_W   = $clog2(BLOCK_COUNT);
   localparam int BB_W     = $clog2(BLOCK_BYTES + 1);
   localparam int MAX_FIT  = (1 << OFF_W) / BLOCK_BYTES;
   localparam int USABLE   = (BLOCK_COUNT < MAX_FIT) ? BLOCK_COUNT : MAX_FIT;
   localparam int USABLE_BYTES = USABLE * BLOCK_BYTES;
   // reciprocal ceil(2^32 / BLOCK_BYTES) in 31 bits: exact quotient for any 16-bit offset when BLOCK_BYTES > 2
   localparam longint unsigned RECIP = ((64'd1 << 32) + BLOCK_BYTES - 1) / BLOCK_BYTES;
   localparam int RECIP_W  = 31;
   localparam int DIVP_W   = OFF_W + RECIP_W;
   localparam int QUOT_W   = DIVP_W - 32;
   localparam int BACK_W   = QUOT_W + BB_W;
   localparam int APROD_W  = IDX_W + BB_W;

   localparam logic [IDX_W-1:0]   NULL_IDX   = IDX_W'(BLOCK_COUNT);
   localparam logic [IDX_W-1:0]   USABLE_IDX = IDX_W'(USABLE);
   localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(BLOCK_COUNT - 1);
   localparam logic [BB_W-1:0]    BYTES_K    = BB_W'(BLOCK_BYTES);
   localparam logic [RECIP_W-1:0] RECIP_K    = RECIP[RECIP_W-1:0];
   localparam logic [OFF_W:0]     END_K      = (OFF_W + 1)'(USABLE_BYTES);

   logic [IDX_W-1:0]  next_table [BLOCK_COUNT];

   logic [IDX_W-1:0]  head_ff;
   logic [ADDR_W-1:0] init_addr_ff;
   logic [IDX_W-1:0]  rd_ff;
   logic              empty_ff;
   logic [OFF_W-1:0]  aoff_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [QUOT_W-1:0] quot_ff;
   logic              range_ff;
   logic              rsp_valid_ff;
   logic [fbpa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [OFF_W-1:0]  rsp_offset_ff;

   logic              head_ok;
   logic [IDX_W-1:0]  init_next;
   logic [IDX_W-1:0]  init_data;
   logic [DIVP_W-1:0] div_prod;
   logic [BACK_W-1:0] back_prod;
   logic [APROD_W-1:0] alloc_prod;
   logic              aligned;
   logic              free_ok;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [IDX_W-1:0]  wr_data;
   fbpa_pkg::status_type free_status;

   assign head_ok    = (head_ff < USABLE_IDX);
   assign init_next  = IDX_W'(init_addr_ff) + IDX_W'(1);
   assign init_data  = (init_next < USABLE_IDX) ? init_next : NULL_IDX;
   assign div_prod   = DIVP_W'(req_free_offset) * DIVP_W'(RECIP_K);
   assign back_prod  = BACK_W'(quot_ff) * BACK_W'(BYTES_K);
   assign alloc_prod = APROD_W'(head_ff) * APROD_W'(BYTES_K);
   assign aligned    = (back_prod == BACK_W'(off_ff));
   assign free_ok    = !range_ff && aligned;

   always_comb begin
      if (range_ff) begin
         free_status = fbpa_pkg::STATUS_RANGE;
      end else if (!aligned) begin
         free_status = fbpa_pkg::STATUS_MISALIGN;
      end else begin
         free_status = fbpa_pkg::STATUS_OK;
      end
   end

   // one write port: clearing pass or a free pushing onto the list
   always_comb begin
      wr_en   = cmd.init_step | (cmd.finish_free & free_ok);
      wr_addr = cmd.init_step ? init_addr_ff : quot_ff[ADDR_W-1:0];
      wr_data = cmd.init_step ? init_data : (head_ok ? head_ff : NULL_IDX);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         next_table[wr_addr] <= wr_data;
      end
      if (cmd.start_alloc) begin
         rd_ff <= next_table[head_ff[ADDR_W-1:0]];
      end
   end

   assign stat.init_last = (init_addr_ff == LAST_ADDR);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   // request operands
   always_ff @(posedge clock) begin
      if (cmd.start_alloc) begin
         empty_ff <= !head_ok;
         aoff_ff  <= OFF_W'(alloc_prod);
      end
      if (cmd.start_free) begin
         off_ff   <= req_free_offset;
         quot_ff  <= div_prod[DIVP_W-1:32];
         range_ff <= ({1'b0, req_free_offset} >= END_K);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         init_addr_ff <= '0;
      end else begin
         if (cmd.init_step) begin
            init_addr_ff <= init_addr_ff + ADDR_W'(1);
         end
         if (cmd.finish_alloc && !empty_ff) begin
            head_ff <= (rd_ff < USABLE_IDX) ? rd_ff : NULL_IDX;
         end else if (cmd.finish_free && free_ok) begin
            head_ff <= IDX_W'(quot_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish_alloc || cmd.finish_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_alloc) begin
         rsp_status_ff <= empty_ff ? fbpa_pkg::STATUS_EMPTY : fbpa_pkg::STATUS_OK;
         rsp_offset_ff <= empty_ff ? '0 : aoff_ff;
      end else if (cmd.finish_free) begin
         rsp_status_ff <= free_status;
         rsp_offset_ff <= '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_alloc_offset = rsp_offset_ff;

endmodule

// ----- design/fbpa_checker.sv -----
// Port-level checks for the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg; the bind picks the signals out of the top's channels.
module fbpa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fbpa_pkg::STATUS_W-1:0] rsp_status,
   input logic [fbpa_pkg::OFFSET_W-1:0] rsp_alloc_offset
);

   // a stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_alloc_offset))
      else $error("response beat changed while stalled");

   // clearing pass keeps requests out right after reset
   assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back-to-back request accepted");

   // failed responses carry a zero offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != fbpa_pkg::STATUS_OK) |->
         rsp_alloc_offset == '0)
      else $error("nonzero offset on error response");

   // a response beat never rises in the cycle right after a request is accepted
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response beat too early");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_alloc_offset (rsp_chan.alloc_offset)
);
